// ----- rtl/core/ttl_lru_address_map_cache_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the address map cache
// Immediate-implication and next-cycle-implication checks on clk_i/rst_ni.
// ----------------------------------------------------------------------------
`ifndef TTL_LRU_ADDRESS_MAP_CACHE_TOP_ASSERT_SVH
`define TTL_LRU_ADDRESS_MAP_CACHE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TLAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TLAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TLAC_ASSERT_IMP(lbl, ante, cons)
`define TLAC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/tlac_pkg.sv -----
// ----------------------------------------------------------------------------
// tlac_pkg
// Mode codes, configuration indices, table word width and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package tlac_pkg;

  localparam logic [2:0] MODE_PUT      = 3'd0;
  localparam logic [2:0] MODE_LOOKUP   = 3'd1;
  localparam logic [2:0] MODE_CONTAINS = 3'd2;
  localparam logic [2:0] MODE_REMOVE   = 3'd3;
  localparam logic [2:0] MODE_CLEAR    = 3'd4;
  localparam logic [2:0] MODE_TICK     = 3'd5;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  // One table word holds key, value, expiry and recency stamp.
  localparam int unsigned WORD_W = 128;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic finish;
    logic load_out;
  } tlac_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic out_free;
  } tlac_status_t;

endpackage

// ----- rtl/core/tlac_ram.sv -----
// ----------------------------------------------------------------------------
// tlac_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tlac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/core/tlac_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlac_ctrl
// Sequencer: accepts a transaction, walks the table when needed, then hands off the result.
// ----------------------------------------------------------------------------
`include "ttl_lru_address_map_cache_top_assert.svh"
module tlac_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  tlac_pkg::tlac_status_t                  status_i,
  output tlac_pkg::tlac_cmd_t                     cmd_o,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_o
);
  import tlac_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_addr_o  = cnt_q[IW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.start = in_fire;
        if (in_fire) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cnt_d   = '0;
        state_d = status_i.need_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CW'(DEPTH - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `TLAC_ASSERT_NXT(a_accept_decide, in_fire, state_q == ST_DECIDE)
  `TLAC_ASSERT_NXT(a_drain_finish, state_q == ST_DRAIN, state_q == ST_FINISH)
  `TLAC_ASSERT_IMP(a_scan_range, state_q == ST_SCAN, cnt_q < CW'(DEPTH))
endmodule

// ----- rtl/core/tlac_dp.sv -----
// ----------------------------------------------------------------------------
// tlac_dp
// Datapath: table RAM, valid bits, scan trackers, update and result registers.
// ----------------------------------------------------------------------------
`include "ttl_lru_address_map_cache_top_assert.svh"
module tlac_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tlac_pkg::tlac_cmd_t                     cmd_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output tlac_pkg::tlac_status_t                  status_o,
  input  logic [6:0]                              capacity_i,
  input  logic [15:0]                             interval_i,
  input  logic [2:0]                              mode_i,
  input  logic [31:0]                             addr_key_i,
  input  logic [31:0]                             value_handle_i,
  input  logic [19:0]                             ttl_seconds_i,
  input  logic [31:0]                             now_seconds_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic                                    found_o,
  output logic [31:0]                             hit_value_o,
  output logic [31:0]                             hit_expiry_o,
  output logic                                    evicted_one_o,
  output logic [6:0]                              swept_count_o,
  output logic [6:0]                              entry_count_o
);
  import tlac_pkg::*;

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;

  // Transaction held for the duration of the walk.
  logic [2:0]  mode_q;
  logic [31:0] key_q, val_q, now_q;
  logic [19:0] ttl_q;
  logic        need_q, sweep_q;

  logic [DEPTH-1:0] valid_q;
  logic [CW-1:0]    count_q, count_d;
  logic [31:0]      rc_q, nst_q;

  // Scan trackers: key match, first free slot, oldest stamp.
  logic          m_found_q, f_found_q, l_found_q;
  logic [IW-1:0] m_idx_q, f_idx_q, l_idx_q;
  logic [31:0]   m_val_q, m_exp_q, l_age_q;
  logic [CW-1:0] swept_q;

  logic          ev_v_q;
  logic [IW-1:0] ev_idx_q;

  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [31:0] e_key, e_val, e_exp, e_rec, e_age;
  logic        e_valid, e_sweep;

  logic [CMPW-1:0] cap_eff, count_ext, swept_ext;
  logic            ev_c, expired_c;
  logic [IW-1:0]   slot_c;
  logic [32:0]     exp_sum, nst_sum;
  logic [31:0]     exp_c, nst_c;
  logic [15:0]     intv_eff;

  // Result registers, then output registers.
  logic        res_found_q, res_ev_q;
  logic [31:0] res_hv_q, res_he_q;
  logic [6:0]  res_swept_q, res_count_q;
  logic        out_valid_q;

  tlac_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign e_key   = ram_rdata[127:96];
  assign e_val   = ram_rdata[95:64];
  assign e_exp   = ram_rdata[63:32];
  assign e_rec   = ram_rdata[31:0];
  assign e_age   = rc_q - e_rec;
  assign e_valid = valid_q[ev_idx_q];
  assign e_sweep = ev_v_q && sweep_q && e_valid && (now_q >= e_exp);

  always_comb begin
    if (capacity_i == 7'd0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(capacity_i) > CMPW'(DEPTH)) begin
      cap_eff = CMPW'(DEPTH);
    end else begin
      cap_eff = CMPW'(capacity_i);
    end
  end

  assign count_ext = CMPW'(count_q);
  assign ev_c      = (mode_q == MODE_PUT) && !m_found_q && (count_ext >= cap_eff);
  assign expired_c = now_q >= m_exp_q;

  always_comb begin
    if (m_found_q) begin
      slot_c = m_idx_q;
    end else if (ev_c && (!f_found_q || (l_idx_q < f_idx_q))) begin
      slot_c = l_idx_q;
    end else begin
      slot_c = f_idx_q;
    end
  end

  assign exp_sum  = {1'b0, now_q} + {13'd0, ttl_q};
  assign exp_c    = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
  assign intv_eff = (interval_i == 16'd0) ? 16'd1 : interval_i;
  assign nst_sum  = {1'b0, now_q} + {17'd0, intv_eff};
  assign nst_c    = nst_sum[32] ? 32'hFFFF_FFFF : nst_sum[31:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_addr_i;
    ram_wdata = {key_q, val_q, exp_c, rc_q};
    if (cmd_i.finish) begin
      ram_addr = slot_c;
      if (mode_q == MODE_PUT) begin
        ram_we = 1'b1;
      end else if (mode_q == MODE_LOOKUP && m_found_q && !expired_c) begin
        ram_we    = 1'b1;
        ram_wdata = {key_q, m_val_q, m_exp_q, rc_q};
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (e_sweep) begin
      count_d = count_q - 1'b1;
    end else if (cmd_i.finish) begin
      case (mode_q)
        MODE_PUT: if (!m_found_q && !ev_c) count_d = count_q + 1'b1;
        MODE_LOOKUP, MODE_CONTAINS: if (m_found_q && expired_c) count_d = count_q - 1'b1;
        MODE_REMOVE: if (m_found_q) count_d = count_q - 1'b1;
        MODE_CLEAR: count_d = '0;
        default: count_d = count_q;
      endcase
    end
  end

  assign swept_ext = CMPW'(swept_q);

  always_comb begin
    status_o.need_scan = need_q;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      rc_q        <= '0;
      nst_q       <= 32'd60;
      ev_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ev_v_q  <= cmd_i.rd_en;
      if (e_sweep) valid_q[ev_idx_q] <= 1'b0;
      if (cmd_i.finish) begin
        case (mode_q)
          MODE_PUT: begin
            if (ev_c) valid_q[l_idx_q] <= 1'b0;
            valid_q[slot_c] <= 1'b1;
            rc_q            <= rc_q + 32'd1;
          end
          MODE_LOOKUP, MODE_CONTAINS: begin
            if (m_found_q && expired_c) begin
              valid_q[m_idx_q] <= 1'b0;
            end else if (m_found_q && mode_q == MODE_LOOKUP) begin
              rc_q <= rc_q + 32'd1;
            end
          end
          MODE_REMOVE: if (m_found_q) valid_q[m_idx_q] <= 1'b0;
          MODE_CLEAR: valid_q <= '0;
          MODE_TICK: if (sweep_q) nst_q <= nst_c;
          default: ;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: transaction, trackers and results.
  always_ff @(posedge clk_i) begin
    ev_idx_q <= rd_addr_i;
    if (cmd_i.start) begin
      mode_q    <= mode_i;
      key_q     <= addr_key_i;
      val_q     <= value_handle_i;
      ttl_q     <= ttl_seconds_i;
      now_q     <= now_seconds_i;
      sweep_q   <= (mode_i == MODE_TICK) && (now_seconds_i >= nst_q);
      need_q    <= (mode_i inside {MODE_PUT, MODE_LOOKUP, MODE_CONTAINS, MODE_REMOVE})
                   || ((mode_i == MODE_TICK) && (now_seconds_i >= nst_q));
      m_found_q <= 1'b0;
      f_found_q <= 1'b0;
      l_found_q <= 1'b0;
      swept_q   <= '0;
    end
    if (ev_v_q) begin
      if (e_valid && e_key == key_q && !m_found_q) begin
        m_found_q <= 1'b1;
        m_idx_q   <= ev_idx_q;
        m_val_q   <= e_val;
        m_exp_q   <= e_exp;
      end
      if (!e_valid && !f_found_q) begin
        f_found_q <= 1'b1;
        f_idx_q   <= ev_idx_q;
      end
      if (e_valid && (!l_found_q || e_age > l_age_q)) begin
        l_found_q <= 1'b1;
        l_idx_q   <= ev_idx_q;
        l_age_q   <= e_age;
      end
      if (e_sweep) swept_q <= swept_q + 1'b1;
    end
    if (cmd_i.finish) begin
      res_found_q <= (mode_q == MODE_LOOKUP || mode_q == MODE_CONTAINS)
                     && m_found_q && !expired_c;
      res_hv_q    <= (mode_q == MODE_LOOKUP && m_found_q && !expired_c) ? m_val_q : 32'd0;
      res_he_q    <= (mode_q == MODE_LOOKUP && m_found_q && !expired_c) ? m_exp_q : 32'd0;
      res_ev_q    <= ev_c;
      res_swept_q <= (mode_q == MODE_TICK) ? swept_ext[6:0] : 7'd0;
      res_count_q <= 7'(CMPW'(count_d));
    end
    if (cmd_i.load_out) begin
      found_o       <= res_found_q;
      hit_value_o   <= res_hv_q;
      hit_expiry_o  <= res_he_q;
      evicted_one_o <= res_ev_q;
      swept_count_o <= res_swept_q;
      entry_count_o <= res_count_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `TLAC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
  `TLAC_ASSERT_IMP(a_count_match, 1'b1, $countones(valid_q) == int'(count_q))
  `TLAC_ASSERT_NXT(a_swept_tick_only, cmd_i.finish && mode_q != MODE_TICK, res_swept_q == 7'd0)
endmodule

// ----- rtl/core/ttl_lru_address_map_cache_top.sv -----
// ----------------------------------------------------------------------------
// ttl_lru_address_map_cache_top
// Address-keyed cache with per-entry expiry and least-recently-used eviction.
// ----------------------------------------------------------------------------
// Every transaction that needs the table (put, lookup, contains, remove, and
// a tick that reaches its sweep time) walks the whole table once, one slot
// per cycle out of a single-port RAM, before its update and result are
// made; clear, an early tick or an unused mode skips the walk. The result
// is loaded into the output register once that register is free, and the
// next transaction can be accepted in the cycle after the load; none is
// taken while one is still in work. The table walk through the single RAM
// port bounds the transaction rate. A finished result waits in the output
// register while the next transaction is already accepted and worked on;
// a newer result is held back until the output register is free. Valid
// bits live in flip-flops and reset clears them at once, so no clearing
// pass is needed after reset.
module ttl_lru_address_map_cache_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes: index 0 is capacity_limit, index 1 sweep_interval.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] addr_key_i,
  input  logic [31:0] value_handle_i,
  input  logic [19:0] ttl_seconds_i,
  input  logic [31:0] now_seconds_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] hit_value_o,
  output logic [31:0] hit_expiry_o,
  output logic        evicted_one_o,
  output logic [6:0]  swept_count_o,
  output logic [6:0]  entry_count_o
);
  import tlac_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [6:0]   capacity_q;
  logic [15:0]  interval_q;
  tlac_cmd_t    cmd;
  tlac_status_t status;
  logic [IW-1:0] rd_addr;

  // Configuration is always taken; the capacity is clamped where it is used,
  // and a new sweep interval only matters at the next rearm of the sweep.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 7'd64;
      interval_q <= 16'd60;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CAPACITY: capacity_q <= cfg_data_i[6:0];
        CFG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The sequencer steps through accept, table walk, update and hand-off.
  tlac_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  // The datapath owns the table, the trackers filled during the walk and
  // the result registers.
  tlac_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .status_o       (status),
    .capacity_i     (capacity_q),
    .interval_i     (interval_q),
    .mode_i         (mode_i),
    .addr_key_i     (addr_key_i),
    .value_handle_i (value_handle_i),
    .ttl_seconds_i  (ttl_seconds_i),
    .now_seconds_i  (now_seconds_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .hit_value_o    (hit_value_o),
    .hit_expiry_o   (hit_expiry_o),
    .evicted_one_o  (evicted_one_o),
    .swept_count_o  (swept_count_o),
    .entry_count_o  (entry_count_o)
  );
endmodule
